// ===== hw/rtl/ordered_list_engine_top_assert.svh =====
// Assertion macros for the ordered list engine checker.
// Used by olst_chk.sv; expects clk and rst_n in scope.
`ifndef ORDERED_LIST_ENGINE_TOP_ASSERT_SVH
`define ORDERED_LIST_ENGINE_TOP_ASSERT_SVH

// checked outside reset
`define OLST_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ordered list engine assertion failed");

// checked during reset too
`define OLST_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("ordered list engine assertion failed");

`endif

// ===== hw/rtl/olst_pkg.sv =====
// Shared types and constants for the ordered list engine.
// No dependencies.
`default_nettype none

package olst_pkg;

    localparam int DEPTH   = 256;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int CMD_W   = 3;
    localparam int POS_W   = 9;
    localparam int WORD_W  = 32;
    localparam int SHIFT_W = 16;
    localparam int STAT_W  = 3;
    localparam int FOUND_W = 8;
    localparam int CMP_W   = (POS_W > CNT_W) ? POS_W : CNT_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 3'd0,
        CMD_REMOVE = 3'd1,
        CMD_SEARCH = 3'd2,
        CMD_ROTATE = 3'd3,
        CMD_READ   = 3'd4
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 3'd0,
        ST_RANGE = 3'd1,
        ST_FULL  = 3'd2,
        ST_MISS  = 3'd3,
        ST_EMPTY = 3'd4
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_INS_CHK,
        S_INS_WR,
        S_REM_CHK,
        S_REM_WR,
        S_SRCH_CHK,
        S_SRCH_CMP,
        S_ROT_DIV,
        S_REV_CHK,
        S_REV_RHI,
        S_REV_WLO,
        S_REV_WHI,
        S_RD_WAIT,
        S_FIN
    } state_t;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_LOAD,
        DP_SET_RANGE,
        DP_SET_FULL,
        DP_SET_EMPTY,
        DP_INS_INIT,
        DP_INS_RD,
        DP_INS_WR,
        DP_INS_PUT,
        DP_REM_INIT,
        DP_REM_RD,
        DP_REM_WR,
        DP_REM_END,
        DP_SRCH_INIT,
        DP_SRCH_RD,
        DP_SRCH_HIT,
        DP_SRCH_NEXT,
        DP_DIV_START,
        DP_REV_INIT,
        DP_REV_RLO,
        DP_REV_RHI,
        DP_REV_WLO,
        DP_REV_WHI,
        DP_REV_NEXT,
        DP_RD_RD,
        DP_RD_CAP,
        DP_PUBLISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } ctl_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             pos_gt_cnt;
        logic             pos_ge_cnt;
        logic             full;
        logic             empty;
        logic             idx_gt_pos;
        logic             idx_lt_cnt;
        logic             match;
        logic             div_done;
        logic             rev_more;
        logic             rev_last;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/olst_if.sv =====
// Request and response word channels of the ordered list engine.
// Depends on olst_pkg.
`default_nettype none

interface olst_req_if;
    logic                             valid;
    logic                             ready;
    logic [olst_pkg::CMD_W-1:0]       cmd;
    logic [olst_pkg::POS_W-1:0]       position;
    logic signed [olst_pkg::WORD_W-1:0] item_value;
    logic [olst_pkg::SHIFT_W-1:0]     shift_amount;

    modport source (output valid, cmd, position, item_value, shift_amount, input ready);
    modport sink   (input valid, cmd, position, item_value, shift_amount, output ready);
endinterface

interface olst_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [olst_pkg::STAT_W-1:0]        status;
    logic [olst_pkg::FOUND_W-1:0]       found_position;
    logic signed [olst_pkg::WORD_W-1:0] read_value;
    logic [olst_pkg::CNT_W-1:0]         list_length;

    modport source (output valid, status, found_position, read_value, list_length, input ready);
    modport sink   (input valid, status, found_position, read_value, list_length, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/olst_div.sv =====
// Restoring remainder unit, one quotient bit per cycle.
// Depends on olst_pkg.
`default_nettype none

module olst_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [olst_pkg::SHIFT_W-1:0] dividend,
    input  wire logic [olst_pkg::CNT_W-1:0]  divisor,
    output logic                             busy,
    output logic [olst_pkg::CNT_W-1:0]       rem
);
    import olst_pkg::*;

    localparam int STEP_W = $clog2(SHIFT_W + 1);

    logic [SHIFT_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]   rem_reg, rem_next;
    logic [CNT_W-1:0]   dvs_reg, dvs_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               busy_reg, busy_next;
    logic [CNT_W:0]     trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        trial     = {rem_reg, quo_reg[SHIFT_W-1]};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            step_next = STEP_W'(SHIFT_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
                rem_next = CNT_W'(trial - {1'b0, dvs_reg});
            else
                rem_next = CNT_W'(trial);
            quo_next  = {quo_reg[SHIFT_W-2:0], 1'b0};
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy = busy_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/olst_dp.sv =====
// Datapath: entry store, count, walk indices, result registers.
// Depends on olst_pkg and olst_div.
`default_nettype none

module olst_dp (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire olst_pkg::ctl_cmd_t                ctl,
    output olst_pkg::dp_stat_t                     stat,
    input  wire logic [olst_pkg::CMD_W-1:0]        req_cmd,
    input  wire logic [olst_pkg::POS_W-1:0]        req_position,
    input  wire logic signed [olst_pkg::WORD_W-1:0] req_item_value,
    input  wire logic [olst_pkg::SHIFT_W-1:0]      req_shift_amount,
    output logic [olst_pkg::STAT_W-1:0]            rsp_status,
    output logic [olst_pkg::FOUND_W-1:0]           rsp_found_position,
    output logic signed [olst_pkg::WORD_W-1:0]     rsp_read_value,
    output logic [olst_pkg::CNT_W-1:0]             rsp_list_length
);
    import olst_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];

    logic [CMD_W-1:0]   cmd_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [WORD_W-1:0]  word_reg;
    logic [SHIFT_W-1:0] shift_reg;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   lo_reg, lo_next;
    logic [CNT_W-1:0]   hi_reg, hi_next;
    logic [CNT_W-1:0]   k_reg;
    logic [1:0]         phase_reg, phase_next;
    logic [WORD_W-1:0]  tmp_reg;
    logic [WORD_W-1:0]  rdata_reg;
    status_t            res_status_reg, res_status_next;
    logic [FOUND_W-1:0] res_found_reg, res_found_next;
    logic [WORD_W-1:0]  res_value_reg, res_value_next;
    logic [STAT_W-1:0]  out_status_reg;
    logic [FOUND_W-1:0] out_found_reg;
    logic [WORD_W-1:0]  out_value_reg;
    logic [CNT_W-1:0]   out_len_reg;

    logic              we, re;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [WORD_W-1:0] wdata;
    logic              div_busy;
    logic [CNT_W-1:0]  div_rem;
    logic [CMP_W-1:0]  pos_x, cnt_x, idx_x;
    logic [CNT_W-1:0]  hi_m1;

    olst_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.op == DP_DIV_START),
        .dividend (shift_reg),
        .divisor  (cnt_reg),
        .busy     (div_busy),
        .rem      (div_rem)
    );

    assign pos_x = CMP_W'(pos_reg);
    assign cnt_x = CMP_W'(cnt_reg);
    assign idx_x = CMP_W'(idx_reg);
    assign hi_m1 = hi_reg - 1'b1;

    always_comb
    begin
        stat.cmd        = cmd_reg;
        stat.pos_gt_cnt = pos_x > cnt_x;
        stat.pos_ge_cnt = pos_x >= cnt_x;
        stat.full       = cnt_reg == CNT_W'(DEPTH);
        stat.empty      = cnt_reg == '0;
        stat.idx_gt_pos = idx_x > pos_x;
        stat.idx_lt_cnt = idx_reg < cnt_reg;
        stat.match      = rdata_reg == word_reg;
        stat.div_done   = !div_busy;
        stat.rev_more   = ({1'b0, lo_reg} + 1'b1) < {1'b0, hi_reg};
        stat.rev_last   = phase_reg == 2'd2;
    end

    always_comb
    begin
        we              = 1'b0;
        re              = 1'b0;
        waddr           = '0;
        raddr           = '0;
        wdata           = rdata_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        phase_next      = phase_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        res_value_next  = res_value_reg;
        case (ctl.op)
            DP_LOAD:
            begin
                res_status_next = ST_OK;
                res_found_next  = '0;
                res_value_next  = '0;
            end
            DP_SET_RANGE: res_status_next = ST_RANGE;
            DP_SET_FULL:  res_status_next = ST_FULL;
            DP_SET_EMPTY: res_status_next = ST_EMPTY;
            DP_INS_INIT:  idx_next = cnt_reg;
            DP_INS_RD:
            begin
                re    = 1'b1;
                raddr = ADDR_W'(idx_reg - 1'b1);
            end
            DP_INS_WR:
            begin
                we       = 1'b1;
                waddr    = idx_reg[ADDR_W-1:0];
                idx_next = idx_reg - 1'b1;
            end
            DP_INS_PUT:
            begin
                we       = 1'b1;
                waddr    = pos_reg[ADDR_W-1:0];
                wdata    = word_reg;
                cnt_next = cnt_reg + 1'b1;
            end
            DP_REM_INIT: idx_next = CNT_W'(pos_reg) + 1'b1;
            DP_REM_RD, DP_SRCH_RD:
            begin
                re    = 1'b1;
                raddr = idx_reg[ADDR_W-1:0];
            end
            DP_REM_WR:
            begin
                we       = 1'b1;
                waddr    = ADDR_W'(idx_reg - 1'b1);
                idx_next = idx_reg + 1'b1;
            end
            DP_REM_END: cnt_next = cnt_reg - 1'b1;
            DP_SRCH_INIT:
            begin
                idx_next        = '0;
                res_status_next = ST_MISS;
            end
            DP_SRCH_HIT:
            begin
                res_status_next = ST_OK;
                res_found_next  = FOUND_W'(idx_reg);
            end
            DP_SRCH_NEXT: idx_next = idx_reg + 1'b1;
            DP_REV_INIT:
            begin
                phase_next = 2'd0;
                lo_next    = '0;
                hi_next    = div_rem;
            end
            DP_REV_RLO:
            begin
                re    = 1'b1;
                raddr = lo_reg[ADDR_W-1:0];
            end
            DP_REV_RHI:
            begin
                re    = 1'b1;
                raddr = hi_m1[ADDR_W-1:0];
            end
            DP_REV_WLO:
            begin
                we    = 1'b1;
                waddr = lo_reg[ADDR_W-1:0];
            end
            DP_REV_WHI:
            begin
                we      = 1'b1;
                waddr   = hi_m1[ADDR_W-1:0];
                wdata   = tmp_reg;
                lo_next = lo_reg + 1'b1;
                hi_next = hi_m1;
            end
            DP_REV_NEXT:
            begin
                phase_next = phase_reg + 1'b1;
                lo_next    = (phase_reg == 2'd0) ? k_reg : '0;
                hi_next    = cnt_reg;
            end
            DP_RD_RD:
            begin
                re    = 1'b1;
                raddr = pos_reg[ADDR_W-1:0];
            end
            DP_RD_CAP: res_value_next = rdata_reg;
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        phase_reg      <= phase_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        res_value_reg  <= res_value_next;
        if (ctl.op == DP_LOAD)
        begin
            cmd_reg   <= req_cmd;
            pos_reg   <= req_position;
            word_reg  <= req_item_value;
            shift_reg <= req_shift_amount;
        end
        if (ctl.op == DP_REV_INIT)
            k_reg <= div_rem;
        if (ctl.op == DP_REV_RHI)
            tmp_reg <= rdata_reg;
        if (ctl.op == DP_PUBLISH)
        begin
            out_status_reg <= res_status_reg;
            out_found_reg  <= res_found_reg;
            out_value_reg  <= res_value_reg;
            out_len_reg    <= cnt_reg;
        end
    end

    assign rsp_status         = out_status_reg;
    assign rsp_found_position = out_found_reg;
    assign rsp_read_value     = out_value_reg;
    assign rsp_list_length    = out_len_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/olst_ctrl.sv =====
// Controller: sequences each command over the datapath, owns handshakes.
// Depends on olst_pkg.
`default_nettype none

module olst_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_ready,
    output logic                     rsp_valid,
    input  wire logic                rsp_ready,
    input  wire olst_pkg::dp_stat_t  stat,
    output olst_pkg::ctl_cmd_t       ctl
);
    import olst_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   publish;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (req_valid)
                    state_next = S_DISPATCH;
            S_DISPATCH:
            begin
                case (stat.cmd)
                    CMD_INSERT:
                        state_next = (stat.pos_gt_cnt || stat.full) ? S_FIN : S_INS_CHK;
                    CMD_REMOVE:
                        state_next = stat.pos_ge_cnt ? S_FIN : S_REM_CHK;
                    CMD_SEARCH:
                        state_next = S_SRCH_CHK;
                    CMD_ROTATE:
                        state_next = stat.empty ? S_FIN : S_ROT_DIV;
                    CMD_READ:
                        state_next = stat.pos_ge_cnt ? S_FIN : S_RD_WAIT;
                    default:
                        state_next = S_FIN;
                endcase
            end
            S_INS_CHK:  state_next = stat.idx_gt_pos ? S_INS_WR : S_FIN;
            S_INS_WR:   state_next = S_INS_CHK;
            S_REM_CHK:  state_next = stat.idx_lt_cnt ? S_REM_WR : S_FIN;
            S_REM_WR:   state_next = S_REM_CHK;
            S_SRCH_CHK: state_next = stat.idx_lt_cnt ? S_SRCH_CMP : S_FIN;
            S_SRCH_CMP: state_next = stat.match ? S_FIN : S_SRCH_CHK;
            S_ROT_DIV:
                if (stat.div_done)
                    state_next = S_REV_CHK;
            S_REV_CHK:
            begin
                if (stat.rev_more)
                    state_next = S_REV_RHI;
                else if (stat.rev_last)
                    state_next = S_FIN;
            end
            S_REV_RHI:  state_next = S_REV_WLO;
            S_REV_WLO:  state_next = S_REV_WHI;
            S_REV_WHI:  state_next = S_REV_CHK;
            S_RD_WAIT:  state_next = S_FIN;
            S_FIN:
                if (!out_valid_reg || rsp_ready)
                    state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ctl.op  = DP_NOP;
        publish = 1'b0;
        case (state_reg)
            S_IDLE:
                if (req_valid)
                    ctl.op = DP_LOAD;
            S_DISPATCH:
            begin
                case (stat.cmd)
                    CMD_INSERT:
                    begin
                        if (stat.pos_gt_cnt)
                            ctl.op = DP_SET_RANGE;
                        else if (stat.full)
                            ctl.op = DP_SET_FULL;
                        else
                            ctl.op = DP_INS_INIT;
                    end
                    CMD_REMOVE:
                        ctl.op = stat.pos_ge_cnt ? DP_SET_RANGE : DP_REM_INIT;
                    CMD_SEARCH:
                        ctl.op = DP_SRCH_INIT;
                    CMD_ROTATE:
                        ctl.op = stat.empty ? DP_SET_EMPTY : DP_DIV_START;
                    CMD_READ:
                        ctl.op = stat.pos_ge_cnt ? DP_SET_RANGE : DP_RD_RD;
                    default:
                        ctl.op = DP_NOP;
                endcase
            end
            S_INS_CHK:  ctl.op = stat.idx_gt_pos ? DP_INS_RD : DP_INS_PUT;
            S_INS_WR:   ctl.op = DP_INS_WR;
            S_REM_CHK:  ctl.op = stat.idx_lt_cnt ? DP_REM_RD : DP_REM_END;
            S_REM_WR:   ctl.op = DP_REM_WR;
            S_SRCH_CHK: ctl.op = stat.idx_lt_cnt ? DP_SRCH_RD : DP_NOP;
            S_SRCH_CMP: ctl.op = stat.match ? DP_SRCH_HIT : DP_SRCH_NEXT;
            S_ROT_DIV:
                if (stat.div_done)
                    ctl.op = DP_REV_INIT;
            S_REV_CHK:
            begin
                if (stat.rev_more)
                    ctl.op = DP_REV_RLO;
                else if (!stat.rev_last)
                    ctl.op = DP_REV_NEXT;
            end
            S_REV_RHI:  ctl.op = DP_REV_RHI;
            S_REV_WLO:  ctl.op = DP_REV_WLO;
            S_REV_WHI:  ctl.op = DP_REV_WHI;
            S_RD_WAIT:  ctl.op = DP_RD_CAP;
            S_FIN:
                if (!out_valid_reg || rsp_ready)
                begin
                    ctl.op  = DP_PUBLISH;
                    publish = 1'b1;
                end
            default:    ctl.op = DP_NOP;
        endcase
    end

    always_comb
    begin
        if (publish)
            out_valid_next = 1'b1;
        else if (rsp_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign req_ready = state_reg == S_IDLE;
    assign rsp_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/ordered_list_engine_top.sv =====
// Ordered list engine: packed list of up to 256 signed words with a count.
// Channels: req (sink) carries cmd, position, item_value, shift_amount;
// rsp (source) returns status, found_position, read_value, list_length.
// One response word per request word, in order.
// One command at a time; req.ready is high only while the engine is idle.
// Insert and remove shift the entries between the position and the end, search
// scans from entry 0 until a match, rotate runs the remainder unit and then
// reverses three spans with swaps; read and error responses walk nothing. The
// walk over the entry store sets how long a command runs.
// Response sits in an output register, so the next request is taken while
// it waits; a stalled rsp only holds a finished command in its last state.
// Reset clears the count and the handshake state; no store clearing pass.
// Depends on olst_pkg, olst_if, olst_ctrl, olst_dp.
`default_nettype none

module ordered_list_engine_top (
    input  wire logic   clk,
    input  wire logic   rst_n,
    olst_req_if.sink    req,
    olst_rsp_if.source  rsp
);
    import olst_pkg::*;

    ctl_cmd_t ctl;
    dp_stat_t stat;

    olst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    olst_dp u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .ctl                (ctl),
        .stat               (stat),
        .req_cmd            (req.cmd),
        .req_position       (req.position),
        .req_item_value     (req.item_value),
        .req_shift_amount   (req.shift_amount),
        .rsp_status         (rsp.status),
        .rsp_found_position (rsp.found_position),
        .rsp_read_value     (rsp.read_value),
        .rsp_list_length    (rsp.list_length)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/olst_chk.sv =====
// Port-level checker for the ordered list engine, bound to the top level.
// Depends on olst_pkg and ordered_list_engine_top_assert.svh.
`default_nettype none

`include "ordered_list_engine_top_assert.svh"

module olst_chk (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              rsp_valid,
    input wire logic                              rsp_ready,
    input wire logic [olst_pkg::STAT_W-1:0]       rsp_status,
    input wire logic [olst_pkg::FOUND_W-1:0]      rsp_found_position,
    input wire logic [olst_pkg::WORD_W-1:0]       rsp_read_value,
    input wire logic [olst_pkg::CNT_W-1:0]        rsp_list_length
);
    import olst_pkg::*;

    `OLST_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid)
    `OLST_ASSERT(a_len_max, rsp_valid |-> rsp_list_length <= CNT_W'(DEPTH))
    `OLST_ASSERT(a_full_len, rsp_valid && rsp_status == ST_FULL |-> rsp_list_length == CNT_W'(DEPTH))
    `OLST_ASSERT(a_err_zero, rsp_valid && rsp_status != ST_OK |-> rsp_found_position == '0 && rsp_read_value == '0)
    `OLST_ASSERT_ALWAYS(a_rst_quiet, !rst_n |-> !rsp_valid)

endmodule

bind ordered_list_engine_top olst_chk u_chk (
    .clk                (clk),
    .rst_n              (rst_n),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .rsp_status         (rsp.status),
    .rsp_found_position (rsp.found_position),
    .rsp_read_value     (rsp.read_value),
    .rsp_list_length    (rsp.list_length)
);

`default_nettype wire
